// ===== design/priority_arrival_thread_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority arrival thread scheduler
// Concurrent checks; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_ARRIVAL_THREAD_SCHEDULER_MACROS_SVH
`define PRIORITY_ARRIVAL_THREAD_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on a named clock and active-low reset.
`define PATS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property on the block clock and reset.
`define PATS_ASSERT(lbl, prop, msg) `PATS_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define PATS_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define PATS_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== design/pats_pkg.sv =====
// ----------------------------------------------------------------------------
// pats_pkg
// Shared types and codes of the priority arrival thread scheduler.
// ----------------------------------------------------------------------------
package pats_pkg;

    // Item modes
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_SCHED  = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;
    localparam logic [1:0] MODE_NOP    = 2'd3;

    // Result status codes
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_FULL    = 2'd1;
    localparam logic [1:0] RES_NO_ELIG = 2'd2;

    // Slot status codes
    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_RUNNABLE = 2'd2;

    // Fixed result field widths
    localparam int OUT_SLOT_W = 3;
    localparam int OUT_TIME_W = 16;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  priority_req;
        logic [15:0] arrival_time;
        logic [15:0] run_length;
    } in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  switched;
        logic [OUT_TIME_W-1:0] time_now;
        logic                  all_free;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic create;
        logic nop;
        logic fin_read;
        logic fin_apply;
        logic scan_start;
        logic scan_issue;
        logic select;
        logic load_out;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] mode;
        logic       scan_last;
    } sts_t;

endpackage

// ===== design/pats_ram.sv =====
// ----------------------------------------------------------------------------
// pats_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pats_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/pats_ctrl.sv =====
// ----------------------------------------------------------------------------
// pats_ctrl
// Sequencer of the scheduler: dispatch, finish, slot scan, result hand-off.
// ----------------------------------------------------------------------------
`include "priority_arrival_thread_scheduler_macros.svh"

module pats_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output pats_pkg::cmd_t cmd,
    input  pats_pkg::sts_t sts
);
    import pats_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DISPATCH  = 3'd1;
    localparam logic [2:0] S_FIN_APPLY = 3'd2;
    localparam logic [2:0] S_SCAN      = 3'd3;
    localparam logic [2:0] S_DRAIN     = 3'd4;
    localparam logic [2:0] S_SELECT    = 3'd5;
    localparam logic [2:0] S_RESULT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.mode)
                    MODE_CREATE: begin
                        cmd.create = 1'b1;
                        state_next = S_RESULT;
                    end
                    MODE_SCHED: begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    MODE_FINISH: begin
                        cmd.fin_read = 1'b1;
                        state_next   = S_FIN_APPLY;
                    end
                    MODE_NOP: begin
                        cmd.nop    = 1'b1;
                        state_next = S_RESULT;
                    end
                    default: state_next = S_RESULT;
                endcase
            end
            S_FIN_APPLY: begin
                cmd.fin_apply  = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_SELECT;
            end
            S_SELECT: begin
                cmd.select = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `PATS_ASSERT(a_one_in_flight, s_valid && s_ready |=> !s_ready, "second beat taken while busy")
    `PATS_ASSERT(a_valid_from_result, $rose(m_valid_reg) |-> $past(state_reg == S_RESULT), "result beat raised outside hand-off")
    `PATS_ASSERT(a_load_needs_room, cmd.load_out |-> out_free, "result loaded over an untaken beat")

endmodule

// ===== design/pats_dpath.sv =====
// ----------------------------------------------------------------------------
// pats_dpath
// Slot table, system time, running slot, scan compare and result register.
// ----------------------------------------------------------------------------
`include "priority_arrival_thread_scheduler_macros.svh"

module pats_dpath #(
    parameter int NUM_SLOTS     = 8,
    parameter int PRIORITY_BITS = 8,
    parameter int TIME_BITS     = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  pats_pkg::cmd_t cmd,
    output pats_pkg::sts_t sts,
    input  pats_pkg::in_t  s_item,
    output pats_pkg::out_t m_item
);
    import pats_pkg::*;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int ENTRY_W = PRIORITY_BITS + 2 * TIME_BITS;

    in_t                      item_reg;
    logic [1:0]               status_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     vld_reg;
    logic [SLOT_W-1:0]        run_reg;
    logic [TIME_BITS-1:0]     time_reg;

    logic [SLOT_W-1:0]        scan_idx_reg;
    logic                     eval_pend_reg;
    logic [SLOT_W-1:0]        eval_idx_reg;
    logic                     eval_vld_reg;
    logic                     found_reg;
    logic [SLOT_W-1:0]        best_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;

    logic [1:0]               res_status_reg;
    logic [SLOT_W-1:0]        res_slot_reg;
    logic                     res_switched_reg;
    out_t                     out_reg;

    logic                     free_found;
    logic [SLOT_W-1:0]        free_idx;
    logic                     all_free;
    logic                     run_running;
    logic                     ram_wr_en;
    logic [ENTRY_W-1:0]       ram_wr_data;
    logic                     ram_rd_en;
    logic [SLOT_W-1:0]        ram_rd_addr;
    logic [ENTRY_W-1:0]       ram_rd_data;
    logic [ENTRY_W-1:0]       entry;
    logic [PRIORITY_BITS-1:0] e_prio;
    logic [TIME_BITS-1:0]     e_arr;
    logic [TIME_BITS-1:0]     e_len;
    logic [TIME_BITS:0]       time_sum;
    logic                     eligible;

    // Lowest free slot and the all-free flag
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        all_free   = 1'b1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (status_reg[i] == ST_FREE) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end else begin
                all_free = 1'b0;
            end
        end
    end

    assign run_running = (status_reg[run_reg] == ST_RUNNING);

    // Slot table: priority, arrival, length
    assign ram_wr_en   = cmd.create && free_found;
    assign ram_wr_data = {PRIORITY_BITS'(item_reg.priority_req),
                          TIME_BITS'(item_reg.arrival_time),
                          TIME_BITS'(item_reg.run_length)};
    assign ram_rd_en   = cmd.fin_read || cmd.scan_issue;
    assign ram_rd_addr = cmd.fin_read ? run_reg : scan_idx_reg;

    pats_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (free_idx),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // An entry never written reads as zero
    assign entry    = eval_vld_reg ? ram_rd_data : '0;
    assign e_prio   = entry[ENTRY_W-1 -: PRIORITY_BITS];
    assign e_arr    = entry[2*TIME_BITS-1 -: TIME_BITS];
    assign e_len    = entry[TIME_BITS-1:0];
    assign time_sum = {1'b0, time_reg} + {1'b0, e_len};
    assign eligible = (status_reg[eval_idx_reg] == ST_RUNNABLE) && (e_arr <= time_reg);

    assign sts.mode      = item_reg.mode;
    assign sts.scan_last = (scan_idx_reg == SLOT_W'(NUM_SLOTS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.load_out) begin
            out_reg.status   <= res_status_reg;
            out_reg.slot     <= OUT_SLOT_W'(res_slot_reg);
            out_reg.switched <= res_switched_reg;
            out_reg.time_now <= OUT_TIME_W'(time_reg);
            out_reg.all_free <= all_free;
        end
        if (ram_rd_en) begin
            eval_vld_reg <= vld_reg[ram_rd_addr];
            eval_idx_reg <= ram_rd_addr;
        end
    end

    // Table status, running slot and time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                status_reg[i] <= (i == 0) ? ST_RUNNING : ST_FREE;
            end
            vld_reg  <= '0;
            run_reg  <= '0;
            time_reg <= '0;
        end else begin
            if (ram_wr_en) begin
                status_reg[free_idx] <= ST_RUNNABLE;
                vld_reg[free_idx]    <= 1'b1;
            end
            if (cmd.fin_apply && run_running) begin
                time_reg            <= time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
                status_reg[run_reg] <= ST_FREE;
            end
            if (cmd.select && found_reg && (best_reg != run_reg)) begin
                status_reg[best_reg] <= ST_RUNNING;
                run_reg              <= best_reg;
            end
        end
    end

    // Scan: one slot read per cycle, compare in the cycle after the read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg  <= '0;
            eval_pend_reg <= 1'b0;
            found_reg     <= 1'b0;
            best_reg      <= '0;
            best_prio_reg <= '0;
        end else begin
            eval_pend_reg <= cmd.scan_issue;
            if (cmd.scan_start) begin
                scan_idx_reg  <= '0;
                found_reg     <= 1'b0;
                best_reg      <= '0;
                best_prio_reg <= '0;
            end else begin
                if (cmd.scan_issue) begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                end
                if (eval_pend_reg && eligible && (!found_reg || e_prio > best_prio_reg)) begin
                    found_reg     <= 1'b1;
                    best_reg      <= eval_idx_reg;
                    best_prio_reg <= e_prio;
                end
            end
        end
    end

    // Result fields
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_status_reg   <= RES_OK;
            res_slot_reg     <= '0;
            res_switched_reg <= 1'b0;
        end else begin
            if (cmd.create) begin
                res_status_reg   <= free_found ? RES_OK : RES_FULL;
                res_slot_reg     <= free_found ? free_idx : '0;
                res_switched_reg <= 1'b0;
            end
            if (cmd.nop) begin
                res_status_reg   <= RES_OK;
                res_slot_reg     <= run_reg;
                res_switched_reg <= 1'b0;
            end
            if (cmd.select) begin
                res_status_reg   <= found_reg ? RES_OK : RES_NO_ELIG;
                res_slot_reg     <= found_reg ? best_reg : run_reg;
                res_switched_reg <= found_reg && (best_reg != run_reg);
            end
        end
    end

    assign m_item = out_reg;

    `PATS_ASSERT(a_runnable_written,
        eval_pend_reg && (status_reg[eval_idx_reg] == ST_RUNNABLE) |-> eval_vld_reg,
        "runnable slot without a written entry")
    `PATS_ASSERT(a_pick_running,
        cmd.select && found_reg && (best_reg != run_reg) |=> status_reg[run_reg] == ST_RUNNING,
        "chosen slot not marked running")
    `PATS_ASSERT(a_scan_clean, cmd.scan_issue |-> !cmd.fin_apply && !cmd.create, "table changed during scan")

endmodule

// ===== design/priority_arrival_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// priority_arrival_thread_scheduler
// Non-preemptive priority scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// Input channel s_*: one beat per command (create, schedule, finish then
// schedule, unused mode). Result channel m_*: exactly one beat per
// command beat. One command is worked on at a time. The scan reads one
// slot per cycle through the single read port of the slot table. The next
// command beat can be taken from the cycle after the result is loaded.
// The result sits in an output register, so a new command is taken while an
// earlier result still waits; if the receiver stalls, the finished result
// of the next command holds inside until the register empties.
// Reset (aresetn low, synchronous): slot 0 running, other slots free,
// system time zero, no result pending. Slot table contents need no clearing
// pass: an entry not yet written reads as zero.
// ----------------------------------------------------------------------------
module priority_arrival_thread_scheduler #(
    parameter int NUM_SLOTS     = 8,
    parameter int PRIORITY_BITS = 8,
    parameter int TIME_BITS     = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pats_pkg::in_t  s_item,
    output logic           m_valid,
    input  logic           m_ready,
    output pats_pkg::out_t m_item
);
    import pats_pkg::*;

    // Command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // Sequence each command and own both handshakes
    pats_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Hold the slot table, time and running slot; build the result beat
    pats_dpath #(
        .NUM_SLOTS     (NUM_SLOTS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TIME_BITS     (TIME_BITS)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_item  (s_item),
        .m_item  (m_item)
    );

endmodule

// ===== sim/priority_arrival_thread_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_arrival_thread_scheduler_tb
// Self-checking bench for the priority arrival thread scheduler. A shadow of
// the slot table predicts every result beat; a directed opening covers reset,
// a full table, tie breaks, switching and draining, then constrained random
// traffic runs with idling on both channels, and a closing pass drives the
// system time into saturation.
// ----------------------------------------------------------------------------
module priority_arrival_thread_scheduler_tb;
    import pats_pkg::*;

    localparam int NUM_SLOTS     = 8;
    localparam int RANDOM_ITEMS  = 1850;
    localparam int SETTLE_CYCLES = 2 * (NUM_SLOTS + 5);
    localparam int STALL_LIMIT   = 400;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_item  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_item;

    // Shadow of the slot table, the running slot and the system time
    logic [1:0]  tbl_state  [NUM_SLOTS];
    logic [7:0]  tbl_prio   [NUM_SLOTS];
    logic [15:0] tbl_arrive [NUM_SLOTS];
    logic [15:0] tbl_len    [NUM_SLOTS];
    logic [2:0]  cur_slot;
    logic [15:0] sys_time;

    // Result beats still owed by the block, oldest first
    out_t awaited_outcomes [$];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int hold_left      = 0;
    // Set during stretches in which neither side idles
    bit no_idle        = 1'b0;

    priority_arrival_thread_scheduler DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Highest-priority runnable slot that has already arrived; lowest index
    // wins a tie. Returns -1 when nothing qualifies.
    function automatic int best_eligible();
        int best;
        best = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_state[i] == ST_RUNNABLE && tbl_arrive[i] <= sys_time &&
                (best < 0 || tbl_prio[i] > tbl_prio[best])) begin
                best = i;
            end
        end
        return best;
    endfunction

    // Advance the shadow by one command beat and return the result it owes.
    function automatic out_t apply_command(in_t cmd);
        out_t        res;
        int          pick;
        logic [16:0] sum;
        res  = '0;
        pick = -1;
        case (cmd.mode)
            MODE_CREATE: begin
                // Lowest free slot takes the new task
                for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
                    if (tbl_state[i] == ST_FREE) pick = i;
                end
                if (pick < 0) begin
                    res.status = RES_FULL;
                    res.slot   = '0;
                end else begin
                    tbl_state[pick]  = ST_RUNNABLE;
                    tbl_prio[pick]   = cmd.priority_req;
                    tbl_arrive[pick] = cmd.arrival_time;
                    tbl_len[pick]    = cmd.run_length;
                    res.slot         = 3'(pick);
                end
            end
            MODE_SCHED, MODE_FINISH: begin
                // A finish only counts when the current slot is really running
                if (cmd.mode == MODE_FINISH && tbl_state[cur_slot] == ST_RUNNING) begin
                    sum                 = {1'b0, sys_time} + {1'b0, tbl_len[cur_slot]};
                    sys_time            = sum[16] ? 16'hFFFF : sum[15:0];
                    tbl_state[cur_slot] = ST_FREE;
                end
                pick = best_eligible();
                if (pick < 0) begin
                    res.status = RES_NO_ELIG;
                end else if (pick != int'(cur_slot)) begin
                    // The slot left behind keeps whatever status it had
                    tbl_state[pick] = ST_RUNNING;
                    cur_slot        = 3'(pick);
                    res.switched    = 1'b1;
                end
                res.slot = cur_slot;
            end
            default: begin
                res.slot = cur_slot;
            end
        endcase
        res.time_now = sys_time;
        res.all_free = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_state[i] != ST_FREE) res.all_free = 1'b0;
        end
        return res;
    endfunction

    function automatic in_t make_cmd(logic [1:0] mode, logic [7:0] prio,
                                     logic [15:0] arrive, logic [15:0] len);
        in_t cmd;
        cmd.mode         = mode;
        cmd.priority_req = prio;
        cmd.arrival_time = arrive;
        cmd.run_length   = len;
        return cmd;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Offer one command beat, hold it until taken, then log what it owes.
    task automatic push_command(in_t cmd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= cmd;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        awaited_outcomes.push_back(apply_command(cmd));
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_all_outcomes();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_outcomes.size() != 0);
    endtask

    // Result side: take each beat, check it field by field against the
    // oldest prediction, and draw a fresh stall for the next one.
    always @(posedge aclk) begin : result_check
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_outcomes.size() == 0) begin
                    report_mismatch("result with nothing awaited", m_item.slot, 0);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (m_item.status !== want.status)
                        report_mismatch("status", m_item.status, want.status);
                    if (m_item.slot !== want.slot)
                        report_mismatch("slot", m_item.slot, want.slot);
                    if (m_item.switched !== want.switched)
                        report_mismatch("switched", m_item.switched, want.switched);
                    if (m_item.time_now !== want.time_now)
                        report_mismatch("time_now", m_item.time_now, want.time_now);
                    if (m_item.all_free !== want.all_free)
                        report_mismatch("all_free", m_item.all_free, want.all_free);
                end
                hold_left = no_idle ? 0 : $urandom_range(0, 3);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_ready <= (hold_left == 0);
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Straight out of reset: nothing runnable, the unused mode, then finish
    // slot 0 (leaves every slot free) and finish again once it is gone.
    task automatic test_reset_state();
        push_command(make_cmd(MODE_SCHED, 8'h00, 16'h0000, 16'h0000));
        push_command(make_cmd(MODE_NOP, 8'hFF, 16'hFFFF, 16'hFFFF));
        push_command(make_cmd(MODE_FINISH, 8'h00, 16'h0000, 16'h0000));
        push_command(make_cmd(MODE_FINISH, 8'h00, 16'h0000, 16'h0000));
    endtask

    // Fill every slot, with equal top priorities to exercise the tie break,
    // then one more create that must bounce off the full table.
    task automatic test_table_full();
        logic [7:0]  prios [NUM_SLOTS] = '{8'd0, 8'd255, 8'd7, 8'd255,
                                           8'd40, 8'd7, 8'd128, 8'd1};
        logic [15:0] lens  [NUM_SLOTS] = '{16'd3, 16'd1, 16'd4, 16'd1,
                                           16'd5, 16'd9, 16'd2, 16'd6};
        for (int i = 0; i < NUM_SLOTS; i++) begin
            push_command(make_cmd(MODE_CREATE, prios[i], 16'h0000, lens[i]));
        end
        push_command(make_cmd(MODE_CREATE, 8'hFF, 16'hFFFF, 16'hFFFF));
    endtask

    // First schedule leaves a runnable slot behind; the second switches away
    // from a running slot, which stays marked running.
    task automatic test_schedule_pick();
        push_command(make_cmd(MODE_SCHED, 8'h00, 16'h0000, 16'h0000));
        push_command(make_cmd(MODE_SCHED, 8'h00, 16'h0000, 16'h0000));
    endtask

    // Finish down the table in priority order until nothing runnable is left, and
    // once more after the current slot has already been freed.
    task automatic test_finish_drain();
        repeat (NUM_SLOTS) push_command(make_cmd(MODE_FINISH, 8'h00, 16'h0000, 16'h0000));
    endtask

    // Mostly creates and finishes around the current time. A schedule that
    // would strand a running slot forever is turned into a finish, bar a
    // couple of rare ones, so the table keeps cycling.
    task automatic test_random_traffic();
        int  counted;
        int  leaks_left;
        int  pick;
        int  arrive;
        in_t cmd;
        counted    = 0;
        leaks_left = 2;
        while (counted < RANDOM_ITEMS) begin
            cmd.priority_req = 8'($urandom);
            cmd.arrival_time = 16'($urandom);
            cmd.run_length   = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                cmd.mode = MODE_CREATE;
            end else if (pick < 85) begin
                cmd.mode = MODE_FINISH;
            end else if (pick < 97) begin
                cmd.mode = MODE_SCHED;
            end else begin
                cmd.mode = MODE_NOP;
            end
            if (cmd.mode == MODE_SCHED && tbl_state[cur_slot] == ST_RUNNING &&
                best_eligible() >= 0) begin
                if (leaks_left > 0 && $urandom_range(0, 199) == 0) begin
                    leaks_left--;
                end else begin
                    cmd.mode = MODE_FINISH;
                end
            end
            if (cmd.mode == MODE_CREATE) begin
                // Arrive a little before or after now, so some tasks wait
                arrive = int'(sys_time);
                arrive += int'($urandom_range(0, 24)) - 8;
                if (arrive < 0) arrive = 0;
                if (arrive > 65535) arrive = 65535;
                cmd.arrival_time = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'(arrive);
                // Keep run lengths short so the time does not saturate early
                cmd.run_length = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 255))
                                                              : 16'($urandom_range(0, 15));
                // Lift a current slot that finish cannot clear
                if (tbl_state[cur_slot] != ST_RUNNING && $urandom_range(0, 3) == 0)
                    cmd.priority_req = 8'hFF;
            end
            push_command(cmd);
            if (cmd.mode != MODE_NOP) begin
                counted++;
                if (counted % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
                if (counted % 300 == 150) wait_all_outcomes();
            end
        end
        no_idle = 1'b0;
    endtask

    // Clear what is runnable, park a task that only arrives at the last time
    // value, then run two maximum-length tasks to pin the time at its top.
    task automatic test_time_saturation();
        for (int n = 0; n < 2 * NUM_SLOTS; n++) begin
            if (tbl_state[cur_slot] == ST_RUNNING || best_eligible() >= 0)
                push_command(make_cmd(MODE_FINISH, 8'h00, 16'h0000, 16'h0000));
        end
        push_command(make_cmd(MODE_CREATE, 8'hFF, 16'hFFFF, 16'hFFFF));
        push_command(make_cmd(MODE_CREATE, 8'h00, 16'h0000, 16'hFFFF));
        push_command(make_cmd(MODE_SCHED, 8'h00, 16'h0000, 16'h0000));
        repeat (3) push_command(make_cmd(MODE_FINISH, 8'h00, 16'h0000, 16'h0000));
    endtask

    initial begin
        // Shadow starts as the block comes out of reset
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tbl_state[i]  = ST_FREE;
            tbl_prio[i]   = '0;
            tbl_arrive[i] = '0;
            tbl_len[i]    = '0;
        end
        tbl_state[0] = ST_RUNNING;
        cur_slot     = '0;
        sys_time     = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_table_full();
        test_schedule_pick();
        test_finish_drain();
        test_random_traffic();
        test_time_saturation();

        wait_all_outcomes();
        // Leave room for any stray beat to show up
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
